>>> rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication on aclk, off during reset
`define ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication on aclk, off during reset
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> rtl/ptts_pkg.sv
`timescale 1ns / 1ps

package ptts_pkg;

    localparam int MAX_TASKS = 8;
    localparam int IDX_W     = $clog2(MAX_TASKS);
    localparam int SLOT_W    = 3;
    localparam int TAG_W     = 8;
    localparam int MS_W      = 16;
    localparam int TICK_W    = 10;
    localparam int PEND_W    = 8;
    localparam logic [TICK_W-1:0] TICK_MS_RESET = TICK_W'(10);

    typedef enum logic [1:0] {
        CMD_TICK     = 2'd0,
        CMD_ADD      = 2'd1,
        CMD_DELETE   = 2'd2,
        CMD_DISPATCH = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_ADDED     = 3'd0,
        ST_FULL      = 3'd1,
        ST_DEL_USED  = 3'd2,
        ST_DEL_EMPTY = 3'd3,
        ST_DUE       = 3'd4,
        ST_NONE      = 3'd5,
        ST_TICK      = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIVIDE,
        S_TICK_WALK,
        S_DISP_WALK,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic             load;
        logic             step_tick;
        logic             step_disp;
        logic             finish;
        logic [IDX_W-1:0] idx;
    } dp_cmd_t;

    typedef struct packed {
        logic out_busy;
        logic div_done;
        logic cur_pending;
        logic any_posted;
    } dp_stat_t;

endpackage

>>> rtl/ptts_div.sv
`timescale 1ns / 1ps

module ptts_div import ptts_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [MS_W-1:0]   num_a,
    input  logic [MS_W-1:0]   num_b,
    input  logic [TICK_W-1:0] den,
    output logic              done,
    output logic [MS_W-1:0]   quo_a,
    output logic [MS_W-1:0]   quo_b
);

    localparam int CNT_W = $clog2(MS_W);

    logic              run_reg, run_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [TICK_W-1:0] den_reg;
    logic [TICK_W-1:0] rem_a_reg, rem_a_next, rem_b_reg, rem_b_next;
    logic [MS_W-1:0]   q_a_reg, q_a_next, q_b_reg, q_b_next;

    function automatic logic [TICK_W+MS_W-1:0] div_step(
        input logic [TICK_W-1:0] rem,
        input logic [MS_W-1:0]   q,
        input logic [TICK_W-1:0] d
    );
        logic [TICK_W:0] shifted;
        logic [TICK_W:0] diff;
        logic            fits;
        shifted = {rem, q[MS_W-1]};
        diff    = shifted - {1'b0, d};
        fits    = (shifted >= {1'b0, d});
        if (fits) begin
            div_step = {diff[TICK_W-1:0], q[MS_W-2:0], 1'b1};
        end else begin
            div_step = {shifted[TICK_W-1:0], q[MS_W-2:0], 1'b0};
        end
    endfunction

    always_comb begin
        run_next   = run_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        rem_a_next = rem_a_reg;
        rem_b_next = rem_b_reg;
        q_a_next   = q_a_reg;
        q_b_next   = q_b_reg;
        if (start) begin
            run_next   = 1'b1;
            cnt_next   = '0;
            rem_a_next = '0;
            rem_b_next = '0;
            q_a_next   = num_a;
            q_b_next   = num_b;
        end else if (run_reg) begin
            {rem_a_next, q_a_next} = div_step(rem_a_reg, q_a_reg, den_reg);
            {rem_b_next, q_b_next} = div_step(rem_b_reg, q_b_reg, den_reg);
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(MS_W - 1)) begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        if (start) begin
            den_reg <= den;
        end
        rem_a_reg <= rem_a_next;
        rem_b_reg <= rem_b_next;
        q_a_reg   <= q_a_next;
        q_b_reg   <= q_b_next;
    end

    assign done  = done_reg;
    assign quo_a = q_a_reg;
    assign quo_b = q_b_reg;

endmodule

>>> rtl/ptts_datapath.sv
`timescale 1ns / 1ps

module ptts_datapath import ptts_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  dp_cmd_t           cmd,
    output dp_stat_t          stat,
    input  logic              cfg_we,
    input  logic [TICK_W-1:0] cfg_wdata,
    input  logic [1:0]        s_command,
    input  logic [TAG_W-1:0]  s_task_tag,
    input  logic [MS_W-1:0]   s_delay_ms,
    input  logic [MS_W-1:0]   s_period_ms,
    input  logic [SLOT_W-1:0] s_slot,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [2:0]        m_status,
    output logic [SLOT_W-1:0] m_slot_index,
    output logic [TAG_W-1:0]  m_due_tag,
    output logic              m_last
);

    logic [TICK_W-1:0] tick_ms_reg;
    logic [TICK_W-1:0] divisor;

    cmd_t              cmd_reg;
    logic [TAG_W-1:0]  tag_in_reg;
    logic [SLOT_W-1:0] sel_reg;
    logic              any_posted_reg;

    logic [MAX_TASKS-1:0] used_reg, used_next;
    logic [TAG_W-1:0]     tag_reg  [MAX_TASKS], tag_next  [MAX_TASKS];
    logic [MS_W-1:0]      cd_reg   [MAX_TASKS], cd_next   [MAX_TASKS];
    logic [MS_W-1:0]      rld_reg  [MAX_TASKS], rld_next  [MAX_TASKS];
    logic [PEND_W-1:0]    pend_reg [MAX_TASKS], pend_next [MAX_TASKS];

    logic              out_valid_reg;
    status_t           out_status_reg;
    logic [SLOT_W-1:0] out_slot_reg;
    logic [TAG_W-1:0]  out_tag_reg;
    logic              out_last_reg;

    logic              post;
    status_t           post_status;
    logic [SLOT_W-1:0] post_slot;
    logic [TAG_W-1:0]  post_tag;
    logic              post_last;

    logic              div_done;
    logic [MS_W-1:0]   quo_delay, quo_period;

    logic [MAX_TASKS-1:0] pend_nz;
    logic                 higher_pending;
    logic                 full;
    logic [IDX_W-1:0]     free_idx;
    logic [MS_W-1:0]      cd_dec;
    logic                 sel_ok;
    logic [IDX_W-1:0]     sel_idx;

    assign divisor = (tick_ms_reg == '0) ? TICK_W'(1) : tick_ms_reg;

    ptts_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.load && (cmd_t'(s_command) == CMD_ADD)),
        .num_a   (s_delay_ms),
        .num_b   (s_period_ms),
        .den     (divisor),
        .done    (div_done),
        .quo_a   (quo_delay),
        .quo_b   (quo_period)
    );

    always_comb begin
        full     = 1'b1;
        free_idx = '0;
        for (int i = MAX_TASKS - 1; i >= 0; i--) begin
            pend_nz[i] = (pend_reg[i] != '0);
            if (!used_reg[i]) begin
                full     = 1'b0;
                free_idx = IDX_W'(i);
            end
        end
        higher_pending = 1'b0;
        for (int j = 0; j < MAX_TASKS; j++) begin
            if ((j > int'(cmd.idx)) && pend_nz[j]) begin
                higher_pending = 1'b1;
            end
        end
    end

    assign cd_dec  = cd_reg[cmd.idx] - 1'b1;
    assign sel_ok  = (int'(sel_reg) < MAX_TASKS);
    assign sel_idx = sel_reg[IDX_W-1:0];

    always_comb begin
        used_next   = used_reg;
        tag_next    = tag_reg;
        cd_next     = cd_reg;
        rld_next    = rld_reg;
        pend_next   = pend_reg;
        post        = 1'b0;
        post_status = ST_TICK;
        post_slot   = '0;
        post_tag    = '0;
        post_last   = 1'b1;

        if (cmd.step_tick) begin
            if (used_reg[cmd.idx] && (cd_reg[cmd.idx] != '0)) begin
                if (cd_dec == '0) begin
                    if (pend_reg[cmd.idx] != '1) begin
                        pend_next[cmd.idx] = pend_reg[cmd.idx] + 1'b1;
                    end
                    cd_next[cmd.idx] = rld_reg[cmd.idx];
                end else begin
                    cd_next[cmd.idx] = cd_dec;
                end
            end
        end

        if (cmd.step_disp && pend_nz[cmd.idx]) begin
            post        = 1'b1;
            post_status = ST_DUE;
            post_slot   = SLOT_W'(cmd.idx);
            post_tag    = tag_reg[cmd.idx];
            post_last   = !higher_pending;
            if (rld_reg[cmd.idx] == '0) begin
                used_next[cmd.idx] = 1'b0;
                tag_next[cmd.idx]  = '0;
                cd_next[cmd.idx]   = '0;
                rld_next[cmd.idx]  = '0;
                pend_next[cmd.idx] = '0;
            end else begin
                pend_next[cmd.idx] = pend_reg[cmd.idx] - 1'b1;
            end
        end

        if (cmd.finish) begin
            post = 1'b1;
            case (cmd_reg)
                CMD_TICK: begin
                    post_status = ST_TICK;
                end
                CMD_ADD: begin
                    if (full) begin
                        post_status = ST_FULL;
                    end else begin
                        post_status         = ST_ADDED;
                        post_slot           = SLOT_W'(free_idx);
                        used_next[free_idx] = 1'b1;
                        tag_next[free_idx]  = tag_in_reg;
                        cd_next[free_idx]   = (quo_delay == '0) ? MS_W'(1) : quo_delay;
                        rld_next[free_idx]  = quo_period;
                        pend_next[free_idx] = '0;
                    end
                end
                CMD_DELETE: begin
                    post_slot   = sel_reg;
                    post_status = ST_DEL_EMPTY;
                    if (sel_ok) begin
                        if (used_reg[sel_idx]) begin
                            post_status = ST_DEL_USED;
                        end
                        used_next[sel_idx] = 1'b0;
                        tag_next[sel_idx]  = '0;
                        cd_next[sel_idx]   = '0;
                        rld_next[sel_idx]  = '0;
                        pend_next[sel_idx] = '0;
                    end
                end
                default: begin
                    post_status = ST_NONE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_ms_reg    <= TICK_MS_RESET;
            any_posted_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            used_reg       <= '0;
            for (int i = 0; i < MAX_TASKS; i++) begin
                tag_reg[i]  <= '0;
                cd_reg[i]   <= '0;
                rld_reg[i]  <= '0;
                pend_reg[i] <= '0;
            end
        end else begin
            if (cfg_we) begin
                tick_ms_reg <= cfg_wdata;
            end
            if (cmd.load) begin
                any_posted_reg <= 1'b0;
            end else if (post) begin
                any_posted_reg <= 1'b1;
            end
            if (post) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            used_reg <= used_next;
            tag_reg  <= tag_next;
            cd_reg   <= cd_next;
            rld_reg  <= rld_next;
            pend_reg <= pend_next;
        end
        if (cmd.load) begin
            cmd_reg    <= cmd_t'(s_command);
            tag_in_reg <= s_task_tag;
            sel_reg    <= s_slot;
        end
        if (post) begin
            out_status_reg <= post_status;
            out_slot_reg   <= post_slot;
            out_tag_reg    <= post_tag;
            out_last_reg   <= post_last;
        end
    end

    assign stat.out_busy    = out_valid_reg && !m_ready;
    assign stat.div_done    = div_done;
    assign stat.cur_pending = pend_nz[cmd.idx];
    assign stat.any_posted  = any_posted_reg;

    assign m_valid      = out_valid_reg;
    assign m_status     = out_status_reg;
    assign m_slot_index = out_slot_reg;
    assign m_due_tag    = out_tag_reg;
    assign m_last       = out_last_reg;

endmodule

>>> rtl/ptts_ctrl.sv
`timescale 1ns / 1ps

module ptts_ctrl import ptts_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic [1:0] s_command,
    output logic       s_ready,
    input  dp_stat_t   stat,
    output dp_cmd_t    cmd
);

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] walk_reg, walk_next;
    logic             accept;
    logic             walk_end;
    logic             disp_stall;

    assign accept     = s_valid && (state_reg == S_IDLE);
    assign walk_end   = (walk_reg == IDX_W'(MAX_TASKS - 1));
    assign disp_stall = stat.cur_pending && stat.out_busy;

    always_comb begin
        state_next = state_reg;
        walk_next  = walk_reg;
        case (state_reg)
            S_IDLE: begin
                walk_next = '0;
                if (accept) begin
                    case (cmd_t'(s_command))
                        CMD_TICK:   state_next = S_TICK_WALK;
                        CMD_ADD:    state_next = S_DIVIDE;
                        CMD_DELETE: state_next = S_FINISH;
                        default:    state_next = S_DISP_WALK;
                    endcase
                end
            end
            S_DIVIDE: begin
                if (stat.div_done) begin
                    state_next = S_FINISH;
                end
            end
            S_TICK_WALK: begin
                walk_next = walk_reg + 1'b1;
                if (walk_end) begin
                    state_next = S_FINISH;
                end
            end
            S_DISP_WALK: begin
                if (!disp_stall) begin
                    walk_next = walk_reg + 1'b1;
                    if (walk_end) begin
                        state_next = (stat.any_posted || stat.cur_pending) ? S_IDLE : S_FINISH;
                    end
                end
            end
            S_FINISH: begin
                if (!stat.out_busy) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready        = 1'b0;
        cmd.load       = 1'b0;
        cmd.step_tick  = 1'b0;
        cmd.step_disp  = 1'b0;
        cmd.finish     = 1'b0;
        cmd.idx        = walk_reg;
        case (state_reg)
            S_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            S_TICK_WALK: begin
                cmd.step_tick = 1'b1;
            end
            S_DISP_WALK: begin
                cmd.step_disp = !disp_stall;
            end
            S_FINISH: begin
                cmd.finish = !stat.out_busy;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            walk_reg  <= '0;
        end else begin
            state_reg <= state_next;
            walk_reg  <= walk_next;
        end
    end

endmodule

>>> rtl/periodic_task_tick_scheduler_unit.sv
`timescale 1ns / 1ps
// channel   handshake          payload
// s_        s_valid/s_ready    command, task_tag, delay_ms, period_ms, slot
// m_        m_valid/m_ready    status, slot_index, due_tag, last
// cfg_      cfg_we             cfg_wdata (tick_ms)
//
// one command at a time; delete goes straight to its result, tick walks the 8 slots,
// add runs the 16-step radix-2 divider, dispatch walks the slots (none when none is due)
// a result waits in the output register while the next transaction is accepted
// aresetn is synchronous; it clears the slot table and sets tick_ms to 10
// m_ready low holds the dispatch walk on the next due slot and the final result

module periodic_task_tick_scheduler_unit import ptts_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [TICK_W-1:0] cfg_wdata,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_command,
    input  logic [TAG_W-1:0]  s_task_tag,
    input  logic [MS_W-1:0]   s_delay_ms,
    input  logic [MS_W-1:0]   s_period_ms,
    input  logic [SLOT_W-1:0] s_slot,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [2:0]        m_status,
    output logic [SLOT_W-1:0] m_slot_index,
    output logic [TAG_W-1:0]  m_due_tag,
    output logic              m_last
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    ptts_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_command (s_command),
        .s_ready   (s_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    ptts_datapath u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .stat         (stat),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .s_command    (s_command),
        .s_task_tag   (s_task_tag),
        .s_delay_ms   (s_delay_ms),
        .s_period_ms  (s_period_ms),
        .s_slot       (s_slot),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_slot_index (m_slot_index),
        .m_due_tag    (m_due_tag),
        .m_last       (m_last)
    );

endmodule

>>> rtl/ptts_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ptts_checker import ptts_pkg::*; (
    input logic              aclk,
    input logic              aresetn,
    input logic              m_valid,
    input logic              m_ready,
    input logic [2:0]        m_status,
    input logic [SLOT_W-1:0] m_slot_index,
    input logic [TAG_W-1:0]  m_due_tag,
    input logic              m_last
);

    // a stalled transaction holds its payload
    `ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_status) && $stable(m_due_tag) && $stable(m_slot_index) && $stable(m_last))

    // only dispatch can give more than one result
    `ASSERT_NOW(a_single_last, m_valid && (m_status != ST_DUE), m_last)

    // only a due task carries a tag
    `ASSERT_NOW(a_tag_zero, m_valid && (m_status != ST_DUE), m_due_tag == '0)

    // results without a slot report slot zero
    `ASSERT_NOW(a_slot_zero, m_valid && ((m_status == ST_FULL) || (m_status == ST_TICK) || (m_status == ST_NONE)), m_slot_index == '0)

endmodule

bind periodic_task_tick_scheduler_unit ptts_checker u_ptts_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_status     (m_status),
    .m_slot_index (m_slot_index),
    .m_due_tag    (m_due_tag),
    .m_last       (m_last)
);

>>> sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import ptts_pkg::*;

    localparam int STALL_LIMIT    = 2000;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS    = 17;
    localparam int SAT_TICKS      = 260;
    localparam int IDLE_PCT       = 36;

    typedef struct {
        cmd_t              command;
        logic [TAG_W-1:0]  task_tag;
        logic [MS_W-1:0]   delay_ms;
        logic [MS_W-1:0]   period_ms;
        logic [SLOT_W-1:0] slot;
    } sched_cmd_t;

    typedef struct {
        status_t           status;
        logic [SLOT_W-1:0] slot_index;
        logic [TAG_W-1:0]  due_tag;
        logic              last;
    } sched_report_t;

    logic              aclk        = 1'b0;
    logic              aresetn     = 1'b0;
    logic              cfg_we      = 1'b0;
    logic [TICK_W-1:0] cfg_wdata   = '0;
    logic              s_valid     = 1'b0;
    logic              s_ready;
    logic [1:0]        s_command   = '0;
    logic [TAG_W-1:0]  s_task_tag  = '0;
    logic [MS_W-1:0]   s_delay_ms  = '0;
    logic [MS_W-1:0]   s_period_ms = '0;
    logic [SLOT_W-1:0] s_slot      = '0;
    logic              m_valid;
    logic              m_ready     = 1'b0;
    logic [2:0]        m_status;
    logic [SLOT_W-1:0] m_slot_index;
    logic [TAG_W-1:0]  m_due_tag;
    logic              m_last;

    // scheduler shadow state
    logic              slot_busy   [MAX_TASKS] = '{default: 1'b0};
    logic [TAG_W-1:0]  slot_tag    [MAX_TASKS] = '{default: '0};
    logic [MS_W-1:0]   slot_count  [MAX_TASKS] = '{default: '0};
    logic [MS_W-1:0]   slot_reload [MAX_TASKS] = '{default: '0};
    logic [PEND_W-1:0] slot_runs   [MAX_TASKS] = '{default: '0};
    logic [TICK_W-1:0] tick_ms_shadow = TICK_MS_RESET;

    sched_cmd_t    cmd_q[$];
    sched_report_t pending_reports[$];
    sched_cmd_t    offer;

    int tx_idle_pct = IDLE_PCT;
    int rx_idle_pct = IDLE_PCT;
    int rx_hold_req = 0;
    int rx_hold_seen = 0;
    int rx_hold_left = 0;
    int stall_cycles = 0;
    int mismatches = 0;
    int results_checked = 0;
    int cmd_counts[4] = '{default: 0};
    int due_reports = 0;
    int full_adds = 0;
    int saturated_ticks = 0;

    periodic_task_tick_scheduler_unit dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_command   (s_command),
        .s_task_tag  (s_task_tag),
        .s_delay_ms  (s_delay_ms),
        .s_period_ms (s_period_ms),
        .s_slot      (s_slot),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_status    (m_status),
        .m_slot_index(m_slot_index),
        .m_due_tag   (m_due_tag),
        .m_last      (m_last)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic void clear_slot(input int i);
        slot_busy[i]   = 1'b0;
        slot_tag[i]    = '0;
        slot_count[i]  = '0;
        slot_reload[i] = '0;
        slot_runs[i]   = '0;
    endfunction

    function automatic void predict_reports(input sched_cmd_t c);
        int unsigned   divisor;
        int unsigned   ticks;
        int            first_free;
        int            n;
        sched_report_t r;
        divisor = (tick_ms_shadow == 0) ? 1 : tick_ms_shadow;
        r = '{status: ST_TICK, slot_index: '0, due_tag: '0, last: 1'b1};
        cmd_counts[c.command]++;
        case (c.command)
            CMD_TICK: begin
                for (int i = 0; i < MAX_TASKS; i++) begin
                    if (slot_busy[i] && slot_count[i] != 0) begin
                        slot_count[i]--;
                        if (slot_count[i] == 0) begin
                            if (slot_runs[i] != '1)
                                slot_runs[i]++;
                            else
                                saturated_ticks++;
                            slot_count[i] = slot_reload[i];
                        end
                    end
                end
                pending_reports.push_back(r);
            end
            CMD_ADD: begin
                first_free = -1;
                for (int i = MAX_TASKS - 1; i >= 0; i--)
                    if (!slot_busy[i])
                        first_free = i;
                if (first_free < 0) begin
                    r.status = ST_FULL;
                    full_adds++;
                end else begin
                    ticks = c.delay_ms / divisor;
                    slot_busy[first_free]   = 1'b1;
                    slot_tag[first_free]    = c.task_tag;
                    slot_count[first_free]  = (ticks == 0) ? MS_W'(1) : MS_W'(ticks);
                    slot_reload[first_free] = MS_W'(c.period_ms / divisor);
                    slot_runs[first_free]   = '0;
                    r.status     = ST_ADDED;
                    r.slot_index = SLOT_W'(first_free);
                end
                pending_reports.push_back(r);
            end
            CMD_DELETE: begin
                r.status     = slot_busy[c.slot] ? ST_DEL_USED : ST_DEL_EMPTY;
                r.slot_index = c.slot;
                clear_slot(c.slot);
                pending_reports.push_back(r);
            end
            default: begin
                n = 0;
                for (int i = 0; i < MAX_TASKS; i++) begin
                    if (slot_runs[i] != 0) begin
                        r = '{status: ST_DUE, slot_index: SLOT_W'(i),
                              due_tag: slot_tag[i], last: 1'b0};
                        pending_reports.push_back(r);
                        n++;
                        due_reports++;
                        slot_runs[i]--;
                        if (slot_reload[i] == 0)
                            clear_slot(i);
                    end
                end
                if (n == 0) begin
                    r = '{status: ST_NONE, slot_index: '0, due_tag: '0, last: 1'b1};
                    pending_reports.push_back(r);
                end else begin
                    pending_reports[pending_reports.size() - 1].last = 1'b1;
                end
            end
        endcase
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                predict_reports(offer);
            if (!s_valid || s_ready) begin
                if (cmd_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                    offer = cmd_q.pop_front();
                    s_command   <= offer.command;
                    s_task_tag  <= offer.task_tag;
                    s_delay_ms  <= offer.delay_ms;
                    s_period_ms <= offer.period_ms;
                    s_slot      <= offer.slot;
                    s_valid     <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        sched_report_t exp_r;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_checked++;
                if (pending_reports.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result status=%0d slot=%0d tag=%0d last=%0d",
                             $time, m_status, m_slot_index, m_due_tag, m_last);
                end else begin
                    exp_r = pending_reports.pop_front();
                    if (m_status !== exp_r.status) begin
                        mismatches++;
                        $display("%0t: status mismatch expected %0d actual %0d",
                                 $time, exp_r.status, m_status);
                    end
                    if (m_slot_index !== exp_r.slot_index) begin
                        mismatches++;
                        $display("%0t: slot_index mismatch expected %0d actual %0d",
                                 $time, exp_r.slot_index, m_slot_index);
                    end
                    if (m_due_tag !== exp_r.due_tag) begin
                        mismatches++;
                        $display("%0t: due_tag mismatch expected %0d actual %0d",
                                 $time, exp_r.due_tag, m_due_tag);
                    end
                    if (m_last !== exp_r.last) begin
                        mismatches++;
                        $display("%0t: last mismatch expected %0d actual %0d",
                                 $time, exp_r.last, m_last);
                    end
                end
            end
            if (rx_hold_req != rx_hold_seen) begin
                rx_hold_seen = rx_hold_req;
                rx_hold_left = RX_HOLD_CYCLES;
            end
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: timeout, %0d results still expected", $time,
                     pending_reports.size());
            $display("CHECKS FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic queue_command(input cmd_t cmd, input int tag, input int delay,
                                 input int period, input int slot);
        sched_cmd_t c;
        c.command   = cmd;
        c.task_tag  = TAG_W'(tag);
        c.delay_ms  = MS_W'(delay);
        c.period_ms = MS_W'(period);
        c.slot      = SLOT_W'(slot);
        cmd_q.push_back(c);
    endtask

    function automatic int ms_near(input int unsigned tick, input int max_ticks);
        int v;
        v = tick * $urandom_range(0, max_ticks) + $urandom_range(0, tick - 1);
        return (v > 65535) ? 65535 : v;
    endfunction

    task automatic queue_random_commands(input int count);
        int unsigned tick;
        int          roll;
        int          delay;
        int          period;
        tick = (tick_ms_shadow == 0) ? 1 : tick_ms_shadow;
        repeat (count) begin
            roll   = $urandom_range(0, 99);
            delay  = $urandom_range(0, 65535);
            period = $urandom_range(0, 65535);
            if (roll < 40) begin
                queue_command(CMD_TICK, $urandom_range(0, 255), delay, period,
                              $urandom_range(0, 7));
            end else if (roll < 62) begin
                if ($urandom_range(0, 99) < 85)
                    delay = ms_near(tick, 4);
                roll = $urandom_range(0, 99);
                if (roll < 30)
                    period = $urandom_range(0, tick - 1);
                else if (roll < 90)
                    period = ms_near(tick, 4) + tick;
                queue_command(CMD_ADD, $urandom_range(0, 255), delay,
                              (period > 65535) ? 65535 : period, $urandom_range(0, 7));
            end else if (roll < 78) begin
                queue_command(CMD_DELETE, $urandom_range(0, 255), delay, period,
                              $urandom_range(0, 7));
            end else begin
                queue_command(CMD_DISPATCH, $urandom_range(0, 255), delay, period,
                              $urandom_range(0, 7));
            end
        end
    endtask

    task automatic wait_drained();
        do
            @(negedge aclk);
        while (cmd_q.size() != 0 || s_valid || pending_reports.size() != 0);
    endtask

    task automatic write_tick_ms(input int value);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= TICK_W'(value);
        tick_ms_shadow = TICK_W'(value);
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        int tick_settings[7];
        tick_settings = '{1, 1000, 0, 1023, 10, 2, 37};
        tick_settings[5] = $urandom_range(2, 999);

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // directed commands at the reset tick_ms of 10
        queue_command(CMD_DISPATCH, 0, 0, 0, 0);
        queue_command(CMD_TICK, 8'h3C, 16'hFFFF, 16'hFFFF, 7);
        queue_command(CMD_ADD, 8'hFF, 0, 0, 0);
        queue_command(CMD_ADD, 8'h00, 16'hFFFF, 16'hFFFF, 7);
        queue_command(CMD_ADD, 8'hA5, 9, 9, 0);
        queue_command(CMD_ADD, 8'h5A, 20, 10, 0);
        queue_command(CMD_TICK, 0, 0, 0, 0);
        queue_command(CMD_TICK, 0, 0, 0, 0);
        queue_command(CMD_DISPATCH, 0, 0, 0, 0);
        queue_command(CMD_DELETE, 0, 0, 0, 7);
        queue_command(CMD_DELETE, 0, 0, 0, 1);
        for (int i = 0; i < MAX_TASKS; i++)
            queue_command(CMD_ADD, 8'h10 + i, 0, 10, 0);
        queue_command(CMD_TICK, 0, 0, 0, 0);
        queue_command(CMD_DISPATCH, 0, 0, 0, 0);
        queue_command(CMD_DELETE, 0, 0, 0, 3);
        queue_command(CMD_DISPATCH, 0, 0, 0, 0);
        wait_drained();

        // back-to-back ticks push the periodic slots into saturation
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        repeat (SAT_TICKS)
            queue_command(CMD_TICK, 0, 0, 0, 0);
        queue_command(CMD_DISPATCH, 0, 0, 0, 0);
        wait_drained();
        tx_idle_pct = IDLE_PCT;
        rx_idle_pct = IDLE_PCT;

        foreach (tick_settings[k]) begin
            write_tick_ms(tick_settings[k]);
            if (k == 2)
                rx_hold_req++;
            queue_random_commands(PHASE_ITEMS);
            wait_drained();
        end

        repeat (40) @(posedge aclk);
        $display("covered %0d transactions (%0d tick, %0d add, %0d delete, %0d dispatch)",
                 cmd_counts[0] + cmd_counts[1] + cmd_counts[2] + cmd_counts[3],
                 cmd_counts[0], cmd_counts[1], cmd_counts[2], cmd_counts[3]);
        $display("%0d results checked, %0d due, %0d full-table adds, %0d saturated ticks",
                 results_checked, due_reports, full_adds, saturated_ticks);
        if (mismatches == 0 && pending_reports.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
